[rtl/fpa_pkg.sv]
package fpa_pkg;

	// Width of the internal result path: wide enough for a 64-bit saturation limit
	// and for the largest rounded product before it is clipped.
	localparam int WW = 66;

	localparam logic [3:0] FN_ADD = 4'd0;
	localparam logic [3:0] FN_SUB = 4'd1;
	localparam logic [3:0] FN_MUL = 4'd2;
	localparam logic [3:0] FN_DIV = 4'd3;
	localparam logic [3:0] FN_EQ  = 4'd4;
	localparam logic [3:0] FN_NE  = 4'd5;
	localparam logic [3:0] FN_GT  = 4'd6;
	localparam logic [3:0] FN_LT  = 4'd7;
	localparam logic [3:0] FN_GE  = 4'd8;
	localparam logic [3:0] FN_LE  = 4'd9;
	localparam logic [3:0] FN_MIN = 4'd10;
	localparam logic [3:0] FN_MAX = 4'd11;
	localparam logic [3:0] FN_INC = 4'd12;
	localparam logic [3:0] FN_DEC = 4'd13;
	localparam logic [3:0] FN_I2F = 4'd14;
	localparam logic [3:0] FN_F2I = 4'd15;

	// Side information that travels alongside the divider stages.
	typedef struct packed {
		logic [3:0]           func;
		logic signed [WW-1:0] simple;
		logic signed [WW-1:0] mul_rnd;
		logic                 cmp;
		logic                 neg;
		logic                 dbz;
	} fpa_tag_t;

endpackage

[rtl/fpa_div.sv]
module fpa_div #(
	parameter int NUM_W = 40,
	parameter int DEN_W = 32,
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag,
	output logic             out_valid,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem,
	output logic [DEN_W-1:0] den_out,
	output logic [TAG_W-1:0] tag_out
);

	// Restoring division, one quotient bit per stage; entry 0 is the input side.
	logic             valid_s [0:NUM_W];
	logic [NUM_W-1:0] num_s   [0:NUM_W];
	logic [NUM_W-1:0] quo_s   [0:NUM_W];
	logic [DEN_W-1:0] rem_s   [0:NUM_W];
	logic [DEN_W-1:0] den_s   [0:NUM_W];
	logic [TAG_W-1:0] tag_s   [0:NUM_W];

	assign valid_s[0] = in_valid;
	assign num_s[0]   = num;
	assign quo_s[0]   = '0;
	assign rem_s[0]   = '0;
	assign den_s[0]   = den;
	assign tag_s[0]   = tag;

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [DEN_W:0] trial;
		logic           ge;

		assign trial = {rem_s[i], num_s[i][NUM_W-1]};
		assign ge    = trial >= {1'b0, den_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else if (en) begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[i+1] <= num_s[i] << 1;
				quo_s[i+1] <= {quo_s[i][NUM_W-2:0], ge};
				rem_s[i+1] <= ge ? DEN_W'(trial - {1'b0, den_s[i]}) : DEN_W'(trial);
				den_s[i+1] <= den_s[i];
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign out_valid = valid_s[NUM_W];
	assign quo       = quo_s[NUM_W];
	assign rem       = rem_s[NUM_W];
	assign den_out   = den_s[NUM_W];
	assign tag_out   = tag_s[NUM_W];

endmodule

[rtl/fixed_point_alu.sv]
// Signed fixed-point ALU on raw two's complement values with FRAC_BITS fractional
// bits. One operation is taken per clock cycle while in_ready is high, and every result
// passes through the same stages whatever the opcode: two input stages, a restoring
// divider of 32 + FRAC_BITS one-bit stages that all operations pass through so that
// results stay in order, then a rounding stage and the saturating output register.
// Products and quotients round to nearest with ties away from zero; results saturate
// to the signed DATA_WIDTH-bit range with overflow raised. A divide by zero gives 0
// with divide_by_zero raised. While a result waits with out_ready low the whole
// pipeline holds and in_ready falls with it.
module fixed_point_alu import fpa_pkg::*; #(
	parameter int FRAC_BITS  = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         func,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_value,
	output logic               compare_true,
	output logic               overflow,
	output logic               divide_by_zero
);

	localparam int NUM_W = 32 + FRAC_BITS;
	localparam int DEN_W = 32;
	localparam logic signed [WW-1:0] ONE     = {{(WW-1){1'b0}}, 1'b1};
	localparam logic signed [WW-1:0] SCALE   = ONE <<< FRAC_BITS;
	localparam logic signed [WW-1:0] HALF    = SCALE >>> 1;
	localparam logic signed [WW-1:0] SAT_MAX = (ONE <<< (DATA_WIDTH - 1)) - ONE;
	localparam logic signed [WW-1:0] SAT_MIN = -SAT_MAX - ONE;

	logic en;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Stage 1: operand registers.
	logic               valid_s1;
	logic [3:0]         func_s1;
	logic signed [31:0] a_s1;
	logic signed [31:0] b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= func;
			a_s1    <= operand_a;
			b_s1    <= operand_b;
		end
	end

	logic signed [WW-1:0] a_w;
	logic signed [WW-1:0] b_w;
	logic signed [WW-1:0] simple;
	logic                 cmp;
	logic signed [63:0]   prod;
	logic [31:0]          abs_a;
	logic [31:0]          abs_b;

	assign a_w   = WW'(a_s1);
	assign b_w   = WW'(b_s1);
	assign prod  = 64'(a_s1) * 64'(b_s1);
	assign abs_a = a_s1[31] ? 32'(-a_s1) : 32'(a_s1);
	assign abs_b = b_s1[31] ? 32'(-b_s1) : 32'(b_s1);

	always_comb begin
		case (func_s1)
			FN_ADD:  simple = a_w + b_w;
			FN_SUB:  simple = a_w - b_w;
			FN_MIN:  simple = (a_s1 < b_s1) ? a_w : b_w;
			FN_MAX:  simple = (a_s1 > b_s1) ? a_w : b_w;
			FN_INC:  simple = a_w + ONE;
			FN_DEC:  simple = a_w - ONE;
			FN_I2F:  simple = a_w <<< FRAC_BITS;
			FN_F2I:  simple = a_w >>> FRAC_BITS;
			default: simple = '0;
		endcase
		case (func_s1)
			FN_EQ:   cmp = a_s1 == b_s1;
			FN_NE:   cmp = a_s1 != b_s1;
			FN_GT:   cmp = a_s1 > b_s1;
			FN_LT:   cmp = a_s1 < b_s1;
			FN_GE:   cmp = a_s1 >= b_s1;
			FN_LE:   cmp = a_s1 <= b_s1;
			default: cmp = 1'b0;
		endcase
	end

	// Stage 2: product, simple results and divider operands.
	logic                 valid_s2;
	logic [3:0]           func_s2;
	logic signed [WW-1:0] simple_s2;
	logic                 cmp_s2;
	logic signed [63:0]   prod_s2;
	logic                 neg_s2;
	logic                 dbz_s2;
	logic [NUM_W-1:0]     num_s2;
	logic [DEN_W-1:0]     den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s2   <= func_s1;
			simple_s2 <= simple;
			cmp_s2    <= cmp;
			prod_s2   <= prod;
			neg_s2    <= a_s1[31] ^ b_s1[31];
			dbz_s2    <= (func_s1 == FN_DIV) && (b_s1 == '0);
			num_s2    <= NUM_W'(abs_a) << FRAC_BITS;
			den_s2    <= abs_b;
		end
	end

	// A negative product rounds away from zero by biasing towards minus infinity
	// before the arithmetic shift.
	logic signed [WW-1:0] prod_w;
	logic signed [WW-1:0] mul_rnd;
	fpa_tag_t             tag_in;
	fpa_tag_t             tag_out;

	assign prod_w  = WW'(prod_s2);
	assign mul_rnd = (prod_w + (prod_s2[63] ? (SCALE - HALF - ONE) : HALF)) >>> FRAC_BITS;

	always_comb begin
		tag_in.func    = func_s2;
		tag_in.simple  = simple_s2;
		tag_in.mul_rnd = mul_rnd;
		tag_in.cmp     = cmp_s2;
		tag_in.neg     = neg_s2;
		tag_in.dbz     = dbz_s2;
	end

	logic             dv_valid;
	logic [NUM_W-1:0] dv_quo;
	logic [DEN_W-1:0] dv_rem;
	logic [DEN_W-1:0] dv_den;

	fpa_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W),
		.TAG_W($bits(fpa_tag_t))
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s2),
		.num      (num_s2),
		.den      (den_s2),
		.tag      (tag_in),
		.out_valid(dv_valid),
		.quo      (dv_quo),
		.rem      (dv_rem),
		.den_out  (dv_den),
		.tag_out  (tag_out)
	);

	// The quotient rounds up when twice the remainder reaches the divisor.
	logic                 round_up;
	logic signed [WW-1:0] q_mag;
	logic signed [WW-1:0] r_sel;
	logic                 is_cmp;

	assign round_up = {dv_rem, 1'b0} >= {1'b0, dv_den};
	assign q_mag    = WW'(dv_quo) + (round_up ? ONE : '0);
	assign is_cmp   = tag_out.func inside {[FN_EQ:FN_LE]};

	always_comb begin
		case (tag_out.func)
			FN_MUL:  r_sel = tag_out.mul_rnd;
			FN_DIV:  r_sel = tag_out.dbz ? '0 : (tag_out.neg ? -q_mag : q_mag);
			default: r_sel = tag_out.simple;
		endcase
	end

	// Stage 3: selected result before saturation.
	logic                 valid_s3;
	logic signed [WW-1:0] r_s3;
	logic                 cmp_s3;
	logic                 dbz_s3;
	logic                 iscmp_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s3     <= r_sel;
			cmp_s3   <= tag_out.cmp;
			dbz_s3   <= tag_out.dbz;
			iscmp_s3 <= is_cmp;
		end
	end

	logic signed [WW-1:0] r_sat;
	logic                 ovf;

	always_comb begin
		r_sat = r_s3;
		ovf   = 1'b0;
		if (iscmp_s3 || dbz_s3) begin
			r_sat = '0;
		end else if (r_s3 > SAT_MAX) begin
			r_sat = SAT_MAX;
			ovf   = 1'b1;
		end else if (r_s3 < SAT_MIN) begin
			r_sat = SAT_MIN;
			ovf   = 1'b1;
		end
	end

	// Stage 4: output register.
	logic               valid_s4;
	logic signed [31:0] res_s4;
	logic               cmp_s4;
	logic               ovf_s4;
	logic               dbz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4 <= r_sat[31:0];
			cmp_s4 <= cmp_s3;
			ovf_s4 <= ovf;
			dbz_s4 <= dbz_s3;
		end
	end

	assign out_valid      = valid_s4;
	assign result_value   = res_s4;
	assign compare_true   = cmp_s4;
	assign overflow       = ovf_s4;
	assign divide_by_zero = dbz_s4;

`ifndef NO_ASSERTIONS
	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> result_value == '0 && !overflow)
		else $error("divide by zero result not cleared");

	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && compare_true |-> result_value == '0 && !overflow && !divide_by_zero)
		else $error("comparison beat carries a value or flag");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_s3) && $stable(r_s3))
		else $error("pipeline moved while stalled");
`endif

endmodule

[bench/fixed_point_alu_test.sv]
`timescale 1ns / 100ps

class alu_scoreboard;
	typedef struct {
		logic signed [31:0] value;
		logic               cmp;
		logic               ovf;
		logic               dbz;
	} alu_result_t;

	alu_result_t pending[$];
	int          errors;

	function new();
		errors = 0;
	endfunction

	// Rounds n / d to nearest with ties away from zero; d is never zero here.
	static function longint round_quotient(longint n, longint d);
		bit              neg;
		longint unsigned un;
		longint unsigned ud;
		longint unsigned q;
		neg = (n < 0) != (d < 0);
		un = n < 0 ? -n : n;
		ud = d < 0 ? -d : d;
		q = (2 * un + ud) / (2 * ud);
		return neg ? -q : q;
	endfunction

	function void note_operation(logic [3:0] fn, logic signed [31:0] a_in,
			logic signed [31:0] b_in);
		alu_result_t exp;
		longint      a;
		longint      b;
		longint      r;
		bit          is_cmp;
		a = a_in;
		b = b_in;
		r = 0;
		is_cmp = 0;
		exp.cmp = 0;
		exp.ovf = 0;
		exp.dbz = 0;
		case (fn)
			fpa_pkg::FN_ADD: r = a + b;
			fpa_pkg::FN_SUB: r = a - b;
			fpa_pkg::FN_MUL: r = round_quotient(a * b, 256);
			fpa_pkg::FN_DIV: begin
				if (b == 0) exp.dbz = 1;
				else r = round_quotient(a * 256, b);
			end
			fpa_pkg::FN_EQ: begin is_cmp = 1; exp.cmp = a == b; end
			fpa_pkg::FN_NE: begin is_cmp = 1; exp.cmp = a != b; end
			fpa_pkg::FN_GT: begin is_cmp = 1; exp.cmp = a > b; end
			fpa_pkg::FN_LT: begin is_cmp = 1; exp.cmp = a < b; end
			fpa_pkg::FN_GE: begin is_cmp = 1; exp.cmp = a >= b; end
			fpa_pkg::FN_LE: begin is_cmp = 1; exp.cmp = a <= b; end
			fpa_pkg::FN_MIN: r = a < b ? a : b;
			fpa_pkg::FN_MAX: r = a > b ? a : b;
			fpa_pkg::FN_INC: r = a + 1;
			fpa_pkg::FN_DEC: r = a - 1;
			fpa_pkg::FN_I2F: r = a * 256;
			default: r = a >>> 8;
		endcase
		if (is_cmp) begin
			r = 0;
		end else if (!exp.dbz) begin
			if (r > 64'sd2147483647) begin
				r = 64'sd2147483647;
				exp.ovf = 1;
			end else if (r < -64'sd2147483648) begin
				r = -64'sd2147483648;
				exp.ovf = 1;
			end
		end
		exp.value = r[31:0];
		pending.push_back(exp);
	endfunction

	function void check_result(logic signed [31:0] value, logic cmp, logic ovf, logic dbz);
		alu_result_t exp;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h", $time, value);
			errors++;
			return;
		end
		exp = pending.pop_front();
		if (value !== exp.value) begin
			$display("%0t: result_value expected %h actual %h", $time, exp.value, value);
			errors++;
		end
		if (cmp !== exp.cmp) begin
			$display("%0t: compare_true expected %b actual %b", $time, exp.cmp, cmp);
			errors++;
		end
		if (ovf !== exp.ovf) begin
			$display("%0t: overflow expected %b actual %b", $time, exp.ovf, ovf);
			errors++;
		end
		if (dbz !== exp.dbz) begin
			$display("%0t: divide_by_zero expected %b actual %b", $time, exp.dbz, dbz);
			errors++;
		end
	endfunction
endclass

module fixed_point_alu_test;
	import fpa_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [3:0]         func;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] result_value;
	logic               compare_true;
	logic               overflow;
	logic               divide_by_zero;

	alu_scoreboard alu_sb;
	int            send_idle_pct;
	int            recv_idle_pct;
	bit            hold_off;
	int            quiet_cycles;

	fixed_point_alu i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_value(result_value), .compare_true(compare_true),
		.overflow(overflow), .divide_by_zero(divide_by_zero)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Sends one operation; the beat is taken at a rising edge with valid and ready high.
	// Valid stays high into the next call unless the sender idles first.
	task automatic send_op(logic [3:0] fn, logic signed [31:0] a, logic signed [31:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		func <= fn;
		operand_a <= a;
		operand_b <= b;
		do @(posedge clk); while (!in_ready);
		alu_sb.note_operation(fn, a, b);
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] random_operand();
		case ($urandom_range(5))
			0: return $urandom_range(2047) - 1024;
			1: return $urandom_range(1 << 20) - (1 << 19);
			2: return {$urandom_range(1) ? 32'hffff_ffff : 32'h0} ^ $urandom_range(15);
			3: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_ops(int n);
		logic [3:0] fn;
		logic signed [31:0] a;
		logic signed [31:0] b;
		repeat (n) begin
			fn = 4'($urandom_range(15));
			a = random_operand();
			b = $urandom_range(9) == 0 ? a : random_operand();
			if ($urandom_range(15) == 0) b = 0;
			send_op(fn, a, b);
		end
		in_valid <= 0;
	endtask

	task automatic wait_drained();
		while (alu_sb.pending.size() != 0) @(negedge clk);
	endtask

	// Receiver side: ready changes at the falling edge, results sampled at the rising edge.
	always @(negedge clk) begin
		if (arst_n)
			out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			alu_sb.check_result(result_value, compare_true, overflow, divide_by_zero);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int k;
		logic signed [31:0] edges[6];
		alu_sb = new();
		edges = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 1, 32'sh100};
		arst_n = 0;
		in_valid = 0;
		func = FN_ADD;
		operand_a = 0;
		operand_b = 0;
		out_ready = 0;
		hold_off = 0;
		quiet_cycles = 0;
		send_idle_pct = 13;
		recv_idle_pct = 52;
		repeat (7) @(negedge clk);
		arst_n = 1;

		// Directed: every opcode once, then extremes, rounding ties and divide by zero.
		for (k = 0; k < 16; k++) send_op(k[3:0], edges[k % 6], edges[(k + 1) % 6]);
		send_op(FN_MUL, 32'sh180, 32'sh1);      // exactly half a raw step
		send_op(FN_MUL, -32'sh180, 32'sh1);
		send_op(FN_DIV, 32'sh1, 32'sh200);      // tie in the quotient
		send_op(FN_DIV, 32'sh7fff_ffff, 32'sh1);
		send_op(FN_DIV, 32'sh1234, 0);
		send_op(FN_I2F, 32'sh8000_0000, 0);
		send_op(FN_INC, 32'sh7fff_ffff, 0);
		send_op(FN_DEC, 32'sh8000_0000, 0);
		send_op(FN_MUL, 32'sh8000_0000, 32'sh8000_0000);

		random_ops(200);
		send_idle_pct = 52;
		recv_idle_pct = 13;
		random_ops(200);

		// Long receiver stall while inputs keep coming, so the pipeline fills and backs up.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		fork
			begin
				hold_off = 1;
				repeat (120) @(negedge clk);
				hold_off = 0;
			end
			random_ops(80);
		join
		wait_drained();
		random_ops(200);
		wait_drained();
		repeat (80) @(negedge clk);
		if (alu_sb.errors == 0 && alu_sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
